// ----- rtl/olist_pkg.sv -----
// olist_pkg: shared types and codes for the ordered list engine.
// No dependencies; imported by olist_cell, olist_ctrl and ordered_list_engine_top.
package olist_pkg;

    localparam int VALUE_W = 32;

    localparam logic [1:0] K_INSERT = 2'd0;
    localparam logic [1:0] K_SEARCH = 2'd1;
    localparam logic [1:0] K_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int OCC_W   = 5;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 2;

    // command broadcast to every cell during the execute cycle
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] key;
    } t_cmd;

    // search result accumulated along the row, front to back
    typedef struct packed {
        logic               seen;
        logic               has_prev;
        logic [VALUE_W-1:0] prev_value;
        logic               has_next;
        logic [VALUE_W-1:0] next_value;
    } t_chain;

endpackage

// ----- rtl/olist_cell.sv -----
// olist_cell: one list slot. Holds one entry, compares it to the key and
// shifts toward either neighbor on insert or delete. Depends on olist_pkg.
module olist_cell #(
    parameter int LIST_DEPTH = 16,
    parameter int IDX        = 0
) (
    input  logic                                 i_clk,
    input  olist_pkg::t_cmd                      i_cmd,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]      i_count,
    input  logic [olist_pkg::VALUE_W-1:0]        i_left_value,
    input  logic [olist_pkg::VALUE_W-1:0]        i_right_value,
    input  olist_pkg::t_chain                    i_chain,
    output olist_pkg::t_chain                    o_chain,
    output logic [olist_pkg::VALUE_W-1:0]        o_value
);
    import olist_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH+1);
    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);
    localparam logic             HAS_LEFT = (IDX != 0);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               w_match;
    logic               w_first;
    logic               w_prev_ok;
    logic               w_next_ok;

    assign w_match   = (IDX_C < i_count) && (r_value == i_cmd.key);
    assign w_first   = w_match && !i_chain.seen;
    assign w_prev_ok = w_first && HAS_LEFT;
    assign w_next_ok = w_first && (NEXT_C < i_count);

    always_comb begin
        o_chain.seen       = i_chain.seen | w_match;
        o_chain.has_prev   = i_chain.has_prev | w_prev_ok;
        o_chain.prev_value = i_chain.prev_value | (w_prev_ok ? i_left_value : '0);
        o_chain.has_next   = i_chain.has_next | w_next_ok;
        o_chain.next_value = i_chain.next_value | (w_next_ok ? i_right_value : '0);
    end

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            n_value = i_left_value;
        end else if (i_cmd.del && (i_chain.seen || w_match)) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- rtl/olist_ctrl.sv -----
// olist_ctrl: stream handshake, operation register, entry count and result
// register for the ordered list engine. Depends on olist_pkg.
module olist_ctrl #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [olist_pkg::S_DATA_W-1:0]       s_axis_tdata,
    input  logic [olist_pkg::S_USER_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [olist_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic [olist_pkg::M_USER_W-1:0]       m_axis_tuser,
    output olist_pkg::t_cmd                      o_cmd,
    output logic [$clog2(LIST_DEPTH+1)-1:0]      o_count,
    input  olist_pkg::t_chain                    i_chain
);
    import olist_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH+1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    logic               r_busy;
    logic [1:0]         r_kind;
    logic [VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_m_valid;
    logic [1:0]         r_status;
    logic               r_has_prev;
    logic [VALUE_W-1:0] r_prev_value;
    logic               r_has_next;
    logic [VALUE_W-1:0] r_next_value;
    logic [OCC_W-1:0]   r_occ;
    logic               w_exec;
    logic               w_full;
    logic               w_is_search;
    logic [1:0]         w_status;

    assign s_axis_tready = !r_busy;
    assign w_exec        = r_busy && (!r_m_valid || m_axis_tready);
    assign w_full        = (r_count == DEPTH_C);
    assign w_is_search   = (r_kind == K_SEARCH) && i_chain.seen;

    assign o_cmd.ins = w_exec && (r_kind == K_INSERT) && !w_full;
    assign o_cmd.del = w_exec && (r_kind == K_DELETE);
    assign o_cmd.key = r_key;
    assign o_count   = r_count;

    always_comb begin
        n_count  = r_count;
        w_status = ST_MISS;
        case (r_kind)
            K_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_DONE;
                    n_count  = r_count + 1'b1;
                end
            end
            K_SEARCH: begin
                if (i_chain.seen) begin
                    w_status = ST_DONE;
                end
            end
            K_DELETE: begin
                if (i_chain.seen) begin
                    w_status = ST_DONE;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                w_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser;
            r_key  <= s_axis_tdata;
        end
        if (w_exec) begin
            r_status     <= w_status;
            r_has_prev   <= w_is_search && i_chain.has_prev;
            r_prev_value <= w_is_search ? i_chain.prev_value : '0;
            r_has_next   <= w_is_search && i_chain.has_next;
            r_next_value <= w_is_search ? i_chain.next_value : '0;
            r_occ        <= OCC_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {1'b0, r_occ, r_next_value, r_has_next, r_prev_value, r_has_prev};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec && (r_kind == K_INSERT) && !w_full |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && (r_status == ST_FULL) |-> r_count == DEPTH_C)
        else $error("full status on a list that is not full");

    a_neighbors_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && (r_has_prev || r_has_next) |-> r_status == ST_DONE)
        else $error("neighbor flag without a hit");
`endif

endmodule

// ----- rtl/ordered_list_engine_top.sv -----
// ordered_list_engine_top: top level of the ordered list engine.
// Depends on olist_pkg, olist_cell and olist_ctrl.
//
// Bounded list of signed 32-bit values, newest at the front, held in a row of
// LIST_DEPTH cells. Each input word is one operation (insert at front, search,
// delete first match) and yields exactly one output word. The word is
// registered on accept, then in the execute cycle every cell compares its entry
// against the key, the first hit and its neighbors are picked up along the row,
// and the cells shift by one slot for insert or delete. The next word is taken
// while a result still waits at the output.
module ordered_list_engine_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] has_prev, [32:1] prev_value, [33] has_next, [65:34] next_value,
    // [70:66] occupancy, [71] zero
    output logic [71:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    import olist_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH+1);

    t_cmd               w_cmd;
    logic [CNT_W-1:0]   w_count;
    t_chain             w_chain [LIST_DEPTH+1];
    logic [VALUE_W-1:0] w_value [LIST_DEPTH];

    assign w_chain[0] = '0;

    olist_ctrl #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_cmd         (w_cmd),
        .o_count       (w_count),
        .i_chain       (w_chain[LIST_DEPTH])
    );

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;

        if (g == 0) begin : g_front
            assign w_left = w_cmd.key;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_back
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        olist_cell #(
            .LIST_DEPTH(LIST_DEPTH),
            .IDX       (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_count       (w_count),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .i_chain       (w_chain[g]),
            .o_chain       (w_chain[g+1]),
            .o_value       (w_value[g])
        );
    end

endmodule
